FILE: rtl/char_lcd_4bit_command_sequencer_unit_defines.svh
// Assertion helpers shared by the sequencer RTL.
`ifndef CHAR_LCD_4BIT_COMMAND_SEQUENCER_UNIT_DEFINES_SVH
`define CHAR_LCD_4BIT_COMMAND_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define CLCD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define CLCD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/clcd_pkg.sv
`timescale 1ns / 1ps

package clcd_pkg;

    // Command codes
    localparam logic [2:0] OP_INIT   = 3'd0;
    localparam logic [2:0] OP_CLEAR  = 3'd1;
    localparam logic [2:0] OP_CURSOR = 3'd2;
    localparam logic [2:0] OP_CHAR   = 3'd3;
    localparam logic [2:0] OP_INT    = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_FUNC_SET  = 2'd0;
    localparam logic [1:0] CFG_DISP_CTRL = 2'd1;
    localparam logic [1:0] CFG_ENTRY     = 2'd2;
    localparam logic [1:0] CFG_ROW_BASE  = 2'd3;

    // Decimal conversion sizes
    localparam int MAG_W    = 16;
    localparam int DIGITS   = 5;
    localparam int BCD_W    = DIGITS * 4;

    // Display bytes
    localparam logic [7:0] BYTE_CLEAR = 8'h01;
    localparam logic [7:0] BYTE_MINUS = 8'h2D;
    localparam logic [7:0] BYTE_DDRAM = 8'h80;
    localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;

    // Timing in microseconds
    localparam logic [15:0] WAIT_POWER_UP   = 16'd50000;
    localparam logic [12:0] HOLD_PULSE      = 13'd50;
    localparam logic [12:0] HOLD_BYTE       = 13'd100;
    localparam logic [12:0] HOLD_CLEAR_BYTE = 13'd2100;
    localparam logic [12:0] HOLD_WAKE_FIRST = 13'd5050;
    localparam logic [12:0] HOLD_WAKE       = 13'd200;

endpackage

FILE: rtl/clcd_bin2bcd.sv
`timescale 1ns / 1ps

module clcd_bin2bcd (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [clcd_pkg::MAG_W-1:0]  i_mag,
    output logic                        o_done,
    output logic [clcd_pkg::BCD_W-1:0]  o_bcd
);

    logic [clcd_pkg::MAG_W-1:0] r_bin;
    logic [clcd_pkg::BCD_W-1:0] r_bcd;
    logic [3:0]                 r_cnt;
    logic                       r_busy;
    logic                       r_done;
    logic [clcd_pkg::BCD_W-1:0] n_adj;

    // Add three to every digit of five or more before the shift
    always_comb begin
        for (int d = 0; d < clcd_pkg::DIGITS; d++) begin
            if (r_bcd[d*4 +: 4] >= 4'd5) begin
                n_adj[d*4 +: 4] = r_bcd[d*4 +: 4] + 4'd3;
            end else begin
                n_adj[d*4 +: 4] = r_bcd[d*4 +: 4];
            end
        end
    end

    // One shift-add step per cycle, one step per magnitude bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_bin  <= i_mag;
                r_bcd  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_bcd <= {n_adj[clcd_pkg::BCD_W-2:0], r_bin[clcd_pkg::MAG_W-1]};
                r_bin <= {r_bin[clcd_pkg::MAG_W-2:0], 1'b0};
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'(clcd_pkg::MAG_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule

FILE: rtl/char_lcd_4bit_command_sequencer_unit.sv
// Character display command sequencer for a 4-bit parallel bus. Each input
// beat is one command (init, clear, set cursor, write character, write signed
// integer); each output beat is one bus transfer: register select, nibble (high
// nibble of a byte first), wait before, hold after, and a last flag on the
// command's final transfer. Codes 5 to 7 are taken and produce nothing. One
// command is worked at a time and the input stalls until its final transfer
// is loaded into the output register. Init makes 12 transfers; clear, cursor
// and character make 2. An integer first runs through a shift-add-3
// converter, one bit per cycle over its 16 magnitude bits, then drops leading
// zero digits (up to 4, at least one digit kept) and makes two transfers per
// digit plus two for a minus sign. Configuration writes take effect at once
// and are meant for idle time only.
`timescale 1ns / 1ps
`include "char_lcd_4bit_command_sequencer_unit_defines.svh"

module char_lcd_4bit_command_sequencer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // command channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_operation,
    input  logic        i_row,
    input  logic [5:0]  i_column,
    input  logic [7:0]  i_character,
    input  logic signed [15:0] i_value,
    // transfer channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_register_select,
    output logic [3:0]  o_nibble,
    output logic [15:0] o_wait_before_us,
    output logic [12:0] o_wait_after_us,
    output logic        o_last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_NORM,
        S_EMIT
    } t_state;

    t_state r_state;

    // configuration
    logic [7:0] r_func_set;
    logic [7:0] r_disp_ctrl;
    logic [7:0] r_entry;
    logic [6:0] r_row_base;

    // command context
    logic [2:0] r_op;
    logic       r_row;
    logic [5:0] r_col;
    logic [7:0] r_char;
    logic [3:0] r_step;
    logic       r_neg;
    logic [2:0] r_ndig;
    logic [clcd_pkg::BCD_W-1:0] r_bcd;

    // output register
    logic        r_out_valid;
    logic        r_out_rs;
    logic [3:0]  r_out_nib;
    logic [15:0] r_out_before;
    logic [12:0] r_out_after;
    logic        r_out_last;

    logic                         in_accept;
    logic                         conv_start;
    logic [clcd_pkg::MAG_W-1:0]   raw_value;
    logic [clcd_pkg::MAG_W-1:0]   mag;
    logic                         conv_done;
    logic [clcd_pkg::BCD_W-1:0]   conv_bcd;
    logic                         load;
    logic [7:0]                   cur_byte;
    logic [7:0]                   cursor_sum;
    logic [12:0]                  byte_hold;
    logic                         cur_rs;
    logic [3:0]                   cur_nib;
    logic [15:0]                  cur_before;
    logic [12:0]                  cur_after;
    logic                         cur_last;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && (r_state == S_IDLE);
    assign raw_value  = $unsigned(i_value);
    assign mag        = raw_value[clcd_pkg::MAG_W-1] ? (16'd0 - raw_value) : raw_value;
    assign conv_start = in_accept && (i_operation == clcd_pkg::OP_INT);
    assign load       = (r_state == S_EMIT) && (!r_out_valid || !i_out_stall);
    assign cursor_sum = (r_row ? {1'b0, r_row_base} : 8'd0) + {2'b00, r_col};

    clcd_bin2bcd u_bin2bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (conv_start),
        .i_mag   (mag),
        .o_done  (conv_done),
        .o_bcd   (conv_bcd)
    );

    // Build the transfer for the current step
    always_comb begin
        cur_byte   = clcd_pkg::BYTE_CLEAR;
        byte_hold  = clcd_pkg::HOLD_BYTE;
        cur_rs     = 1'b0;
        cur_before = 16'd0;
        cur_last   = r_step[0];
        case (r_op)
            clcd_pkg::OP_INIT: begin
                cur_last = (r_step == 4'd11);
                case (r_step[3:1])
                    3'd2: cur_byte = r_func_set;
                    3'd3: cur_byte = r_disp_ctrl;
                    3'd4: cur_byte = r_entry;
                    default: begin
                        cur_byte  = clcd_pkg::BYTE_CLEAR;
                        byte_hold = clcd_pkg::HOLD_CLEAR_BYTE;
                    end
                endcase
            end
            clcd_pkg::OP_CLEAR: begin
                byte_hold = clcd_pkg::HOLD_CLEAR_BYTE;
            end
            clcd_pkg::OP_CURSOR: begin
                cur_byte = clcd_pkg::BYTE_DDRAM | cursor_sum;
            end
            clcd_pkg::OP_CHAR: begin
                cur_rs   = 1'b1;
                cur_byte = r_char;
            end
            default: begin
                cur_rs   = 1'b1;
                cur_byte = r_neg ? clcd_pkg::BYTE_MINUS
                                 : {clcd_pkg::ASCII_DIGIT_HI,
                                    r_bcd[clcd_pkg::BCD_W-1 -: 4]};
                cur_last = r_step[0] && !r_neg && (r_ndig == 3'd1);
            end
        endcase

        cur_nib   = r_step[0] ? cur_byte[3:0] : cur_byte[7:4];
        cur_after = r_step[0] ? byte_hold : clcd_pkg::HOLD_PULSE;

        // Wake-up nibbles at the head of init
        if ((r_op == clcd_pkg::OP_INIT) && (r_step < 4'd4)) begin
            cur_nib   = (r_step == 4'd3) ? 4'h2 : 4'h3;
            cur_after = (r_step == 4'd0) ? clcd_pkg::HOLD_WAKE_FIRST : clcd_pkg::HOLD_WAKE;
            cur_before = (r_step == 4'd0) ? clcd_pkg::WAIT_POWER_UP : 16'd0;
        end
    end

    // Sequencer, configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_func_set  <= 8'h28;
            r_disp_ctrl <= 8'h0C;
            r_entry     <= 8'h06;
            r_row_base  <= 7'h40;
        end else begin
            // Take configuration writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    clcd_pkg::CFG_FUNC_SET:  r_func_set  <= i_cfg_data;
                    clcd_pkg::CFG_DISP_CTRL: r_disp_ctrl <= i_cfg_data;
                    clcd_pkg::CFG_ENTRY:     r_entry     <= i_cfg_data;
                    default:                 r_row_base  <= i_cfg_data[6:0];
                endcase
            end

            // Drop the output beat once taken, unless a new one is loaded
            if (r_out_valid && !i_out_stall && !load) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_op   <= i_operation;
                        r_row  <= i_row;
                        r_col  <= i_column;
                        r_char <= i_character;
                        r_neg  <= raw_value[clcd_pkg::MAG_W-1];
                        r_step <= 4'd0;
                        if (i_operation == clcd_pkg::OP_INT) begin
                            r_state <= S_CONV;
                        end else if (i_operation < clcd_pkg::OP_INT) begin
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_CONV: begin
                    if (conv_done) begin
                        r_bcd   <= conv_bcd;
                        r_ndig  <= 3'(clcd_pkg::DIGITS);
                        r_state <= S_NORM;
                    end
                end
                S_NORM: begin
                    // Drop one leading zero digit a cycle, keep at least one
                    if ((r_bcd[clcd_pkg::BCD_W-1 -: 4] == 4'd0) && (r_ndig != 3'd1)) begin
                        r_bcd  <= {r_bcd[clcd_pkg::BCD_W-5:0], 4'd0};
                        r_ndig <= r_ndig - 3'd1;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (load) begin
                        r_out_valid  <= 1'b1;
                        r_out_rs     <= cur_rs;
                        r_out_nib    <= cur_nib;
                        r_out_before <= cur_before;
                        r_out_after  <= cur_after;
                        r_out_last   <= cur_last;
                        r_step       <= r_step + 4'd1;
                        // Advance the integer queue after each low nibble
                        if ((r_op == clcd_pkg::OP_INT) && r_step[0]) begin
                            if (r_neg) begin
                                r_neg <= 1'b0;
                            end else begin
                                r_bcd  <= {r_bcd[clcd_pkg::BCD_W-5:0], 4'd0};
                                r_ndig <= r_ndig - 3'd1;
                            end
                        end
                        if (cur_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_register_select = r_out_rs;
    assign o_nibble          = r_out_nib;
    assign o_wait_before_us  = r_out_before;
    assign o_wait_after_us   = r_out_after;
    assign o_last            = r_out_last;

    `CLCD_ASSERT_NEXT(a_last_ends_cmd, load && cur_last, (r_state == S_IDLE) && o_out_valid && o_last, "final transfer did not end the command")
    `CLCD_ASSERT_IMPL(a_conv_in_conv, conv_done, r_state == S_CONV, "conversion finished outside the conversion state")
    `CLCD_ASSERT_IMPL(a_digits_left, (r_state == S_EMIT) && (r_op == clcd_pkg::OP_INT), r_ndig != 3'd0, "integer emission ran out of digits")

endmodule
